[src/encoder_speed_pid_controller_unit_assert.svh]
// Concurrent assertion macros used by the RTL
`ifndef ENCODER_SPEED_PID_CONTROLLER_UNIT_ASSERT_SVH
`define ENCODER_SPEED_PID_CONTROLLER_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF

`define ESPC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define ESPC_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`else

`define ESPC_ASSERT(label, clk, rst, prop, msg)

`define ESPC_ASSERT_NEXT(label, clk, rst, pre, post, msg)

`endif

`endif

[src/espc_pkg.sv]
package espc_pkg;

   localparam int ESPC_CHANNELS    = 2;
   localparam int ESPC_COUNT_WIDTH = 32;

   localparam int COUNT_PORT_W  = 32;
   localparam int TARGET_W      = 24;
   localparam int SPEED_W       = 32;
   localparam int DRIVE_W       = 17;
   localparam int REG_W         = 16;
   localparam int LIMIT_W       = 24;
   localparam int INTEG_W       = LIMIT_W + 1;
   localparam int DIFF_W        = SPEED_W + 1;
   localparam int DERIV_W       = 44;
   localparam int FRAC_W        = 16;

   localparam int MUL_A_W       = 45;
   localparam int MUL_B_W       = REG_W;
   localparam int PROD_W        = MUL_A_W + MUL_B_W + 1;

   localparam int CSR_INDEX_W   = 4;
   localparam int CSR_DATA_W    = 24;

   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_P      = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_I      = 4'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_D      = 4'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPEED_PULSE = 4'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_PERIOD_FRAC = 4'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_PERIOD_INV  = 4'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_INTEG_LIMIT = 4'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_DRIVE_LIMIT = 4'd7;

   localparam logic CMD_TICK  = 1'b0;
   localparam logic CMD_RESET = 1'b1;

   typedef struct packed {
      logic [REG_W-1:0]   gain_p;
      logic [REG_W-1:0]   gain_i;
      logic [REG_W-1:0]   gain_d;
      logic [REG_W-1:0]   speed_per_pulse;
      logic [REG_W-1:0]   period_fraction;
      logic [REG_W-1:0]   period_inverse;
      logic [LIMIT_W-1:0] integral_limit;
      logic [REG_W-1:0]   drive_limit;
   } espc_cfg_type;

   localparam espc_cfg_type CFG_RESET = '{
      gain_p:          16'd256,
      gain_i:          16'd51,
      gain_d:          16'd51,
      speed_per_pulse: 16'd1477,
      period_fraction: 16'd655,
      period_inverse:  16'd100,
      integral_limit:  24'd256000,
      drive_limit:     16'd1023
   };

   typedef enum logic [3:0] {
      S_IDLE,
      S_DELTA,
      S_MEAS,
      S_ERR,
      S_ERRC,
      S_MPF,
      S_MPI,
      S_MKP,
      S_MKI,
      S_MKD,
      S_SUM,
      S_DRV,
      S_FINISH
   } espc_state_type;

endpackage

[src/espc_if.sv]
interface espc_req_if import espc_pkg::*; ();
   logic                           valid;
   logic                           ready;
   logic                           command;
   logic                           channel;
   logic signed [COUNT_PORT_W-1:0] encoder_count;
   logic signed [TARGET_W-1:0]     target_speed;
   logic                           enable;
   logic                           brake_on_reset;

   modport source (
      output valid, command, channel, encoder_count, target_speed, enable, brake_on_reset,
      input  ready
   );
   modport sink (
      input  valid, command, channel, encoder_count, target_speed, enable, brake_on_reset,
      output ready
   );
endinterface

interface espc_rsp_if import espc_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic                      channel_out;
   logic signed [SPEED_W-1:0] measured_speed;
   logic signed [DRIVE_W-1:0] drive;
   logic                      stopped;
   logic                      brake;

   modport source (
      output valid, channel_out, measured_speed, drive, stopped, brake,
      input  ready
   );
   modport sink (
      input  valid, channel_out, measured_speed, drive, stopped, brake,
      output ready
   );
endinterface

interface espc_csr_if import espc_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (
      output valid, index, data,
      input  ready
   );
   modport sink (
      input  valid, index, data,
      output ready
   );
endinterface

[src/espc_csr.sv]
module espc_csr import espc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   espc_csr_if.sink     csr_if,
   output espc_cfg_type cfg
);

   espc_cfg_type cfg_ff;
   logic         wr_en;

   assign csr_if.ready = 1'b1;
   assign wr_en        = csr_if.valid && csr_if.ready;
   assign cfg          = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else if (wr_en) begin
         case (csr_if.index)
            CSR_GAIN_P:      cfg_ff.gain_p          <= csr_if.data[REG_W-1:0];
            CSR_GAIN_I:      cfg_ff.gain_i          <= csr_if.data[REG_W-1:0];
            CSR_GAIN_D:      cfg_ff.gain_d          <= csr_if.data[REG_W-1:0];
            CSR_SPEED_PULSE: cfg_ff.speed_per_pulse <= csr_if.data[REG_W-1:0];
            CSR_PERIOD_FRAC: cfg_ff.period_fraction <= csr_if.data[REG_W-1:0];
            CSR_PERIOD_INV:  cfg_ff.period_inverse  <= csr_if.data[REG_W-1:0];
            CSR_INTEG_LIMIT: cfg_ff.integral_limit  <= csr_if.data[LIMIT_W-1:0];
            CSR_DRIVE_LIMIT: cfg_ff.drive_limit     <= csr_if.data[REG_W-1:0];
            default: ;
         endcase
      end
   end

endmodule

[src/espc_mul.sv]
module espc_mul import espc_pkg::*; (
   input  logic                      clock,
   input  logic                      load,
   input  logic signed [MUL_A_W-1:0] mul_a,
   input  logic [MUL_B_W-1:0]        mul_b,
   output logic signed [PROD_W-1:0]  prod
);

   logic signed [PROD_W-1:0]  prod_ff;
   logic signed [MUL_B_W:0]   b_s;

   assign b_s  = $signed({1'b0, mul_b});
   assign prod = prod_ff;

   always_ff @(posedge clock) begin
      if (load) begin
         prod_ff <= PROD_W'(mul_a) * PROD_W'(b_s);
      end
   end

endmodule

[src/encoder_speed_pid_controller_unit.sv]
// Channel   Dir  Handshake        Payload
// req_if    in   valid / ready    command channel encoder_count target_speed enable
//                                 brake_on_reset
// rsp_if    out  valid / ready    channel_out measured_speed drive stopped brake
// csr_if    in   valid / ready    index data (ready always high)
//
// A new request is taken only in idle. An enabled tick uses the single multiplier six
// times (speed, integral, derivative, three gains); a disabled or zero-target tick stops
// after the speed product, and a reset command does not use the multiplier at all.
// A finished result sits in the output register; the next request is taken while it
// waits, and the sequencer holds in its last step only if the previous result is untaken.
// Synchronous reset clears the sequencer, the channel state and the output valid, and loads the configuration defaults.
`include "encoder_speed_pid_controller_unit_assert.svh"

module encoder_speed_pid_controller_unit import espc_pkg::*; #(
   parameter int CHANNELS    = ESPC_CHANNELS,
   parameter int COUNT_WIDTH = ESPC_COUNT_WIDTH
) (
   input  logic        clock,
   input  logic        reset,
   espc_req_if.sink    req_if,
   espc_rsp_if.source  rsp_if,
   espc_csr_if.sink    csr_if
);

   localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   localparam logic signed [PROD_W-1:0] P_I32_MAX = PROD_W'(64'sd2147483647);
   localparam logic signed [PROD_W-1:0] P_I32_MIN = PROD_W'(-64'sd2147483648);
   localparam logic signed [PROD_W-1:0] P_DERIV_MAX =
      PROD_W'((64'sd1 <<< (DERIV_W - 1)) - 64'sd1);

   espc_cfg_type   cfg;
   espc_state_type state_ff, state_in;

   logic                          cmd_ff;
   logic                          chin_ff;
   logic [CH_W-1:0]               slot_ff;
   logic [COUNT_WIDTH-1:0]        count_ff;
   logic signed [TARGET_W-1:0]    target_ff;
   logic                          enable_ff;
   logic                          brake_req_ff;

   logic [COUNT_WIDTH-1:0]        last_count_ff [CHANNELS];
   logic signed [INTEG_W-1:0]     integ_sum_ff  [CHANNELS];
   logic signed [SPEED_W-1:0]     prev_err_ff   [CHANNELS];

   logic [COUNT_WIDTH-1:0]        delta_ff;
   logic signed [SPEED_W-1:0]     meas_ff;
   logic signed [SPEED_W-1:0]     err_ff;
   logic signed [DIFF_W-1:0]      diff_ff;
   logic signed [INTEG_W-1:0]     integ_ff;
   logic signed [DERIV_W-1:0]     deriv_ff;
   logic signed [PROD_W-1:0]      acc_ff;
   logic signed [DRIVE_W-1:0]     drive_ff;
   logic                          stopped_ff;
   logic                          brake_ff;

   logic                          rsp_valid_ff;
   logic                          rsp_chan_ff;
   logic signed [SPEED_W-1:0]     rsp_meas_ff;
   logic signed [DRIVE_W-1:0]     rsp_drive_ff;
   logic                          rsp_stopped_ff;
   logic                          rsp_brake_ff;

   logic                          req_xfer;
   logic                          out_free;
   logic                          ctrl_off;
   logic                          mul_load;
   logic signed [MUL_A_W-1:0]     mul_a;
   logic [MUL_B_W-1:0]            mul_b;
   logic signed [PROD_W-1:0]      prod;

   logic signed [SPEED_W-1:0]     meas_sat;
   logic signed [DIFF_W-1:0]      err_wide;
   logic signed [SPEED_W-1:0]     err_sat;
   logic signed [PROD_W-1:0]      integ_sum;
   logic signed [PROD_W-1:0]      int_lim_w;
   logic signed [INTEG_W-1:0]     integ_new;
   logic signed [DERIV_W-1:0]     deriv_sat;
   logic signed [PROD_W-1:0]      drive_trunc;
   logic signed [PROD_W-1:0]      drive_lim_w;
   logic signed [DRIVE_W-1:0]     drive_new;
   logic signed [DRIVE_W-1:0]     drive_lim_s;
   logic signed [INTEG_W-1:0]     integ_lim_s;

   function automatic logic signed [PROD_W-1:0] trunc16(
         input logic signed [PROD_W-1:0] v);
      logic signed [PROD_W-1:0] bias;
      bias = v[PROD_W-1] ? PROD_W'({FRAC_W{1'b1}}) : '0;
      return (v + bias) >>> FRAC_W;
   endfunction

   espc_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_if (csr_if),
      .cfg    (cfg)
   );

   espc_mul u_mul (
      .clock (clock),
      .load  (mul_load),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .prod  (prod)
   );

   assign req_if.ready = (state_ff == S_IDLE);
   assign req_xfer     = req_if.valid && req_if.ready;
   assign out_free     = !rsp_valid_ff || rsp_if.ready;
   assign ctrl_off     = !enable_ff || (target_ff == '0);

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.channel_out    = rsp_chan_ff;
   assign rsp_if.measured_speed = rsp_meas_ff;
   assign rsp_if.drive          = rsp_drive_ff;
   assign rsp_if.stopped        = rsp_stopped_ff;
   assign rsp_if.brake          = rsp_brake_ff;

   assign int_lim_w   = PROD_W'(cfg.integral_limit);
   assign drive_lim_w = PROD_W'(cfg.drive_limit);
   assign drive_lim_s = DRIVE_W'(cfg.drive_limit);
   assign integ_lim_s = INTEG_W'(cfg.integral_limit);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      mul_load = 1'b0;
      mul_a    = '0;
      mul_b    = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_xfer) state_in = S_DELTA;
         end
         S_DELTA: begin
            state_in = (cmd_ff == CMD_RESET) ? S_FINISH : S_MEAS;
         end
         S_MEAS: begin
            mul_load = 1'b1;
            mul_a    = MUL_A_W'($signed(delta_ff));
            mul_b    = cfg.speed_per_pulse;
            state_in = S_ERR;
         end
         S_ERR: begin
            state_in = ctrl_off ? S_FINISH : S_ERRC;
         end
         S_ERRC: begin
            state_in = S_MPF;
         end
         S_MPF: begin
            mul_load = 1'b1;
            mul_a    = MUL_A_W'(err_ff);
            mul_b    = cfg.period_fraction;
            state_in = S_MPI;
         end
         S_MPI: begin
            mul_load = 1'b1;
            mul_a    = MUL_A_W'(diff_ff);
            mul_b    = cfg.period_inverse;
            state_in = S_MKP;
         end
         S_MKP: begin
            mul_load = 1'b1;
            mul_a    = MUL_A_W'(err_ff);
            mul_b    = cfg.gain_p;
            state_in = S_MKI;
         end
         S_MKI: begin
            mul_load = 1'b1;
            mul_a    = MUL_A_W'(integ_ff);
            mul_b    = cfg.gain_i;
            state_in = S_MKD;
         end
         S_MKD: begin
            mul_load = 1'b1;
            mul_a    = MUL_A_W'(deriv_ff);
            mul_b    = cfg.gain_d;
            state_in = S_SUM;
         end
         S_SUM: begin
            state_in = S_DRV;
         end
         S_DRV: begin
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (out_free) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (prod > P_I32_MAX) begin
         meas_sat = SPEED_W'(P_I32_MAX);
      end else if (prod < P_I32_MIN) begin
         meas_sat = SPEED_W'(P_I32_MIN);
      end else begin
         meas_sat = SPEED_W'(prod);
      end

      err_wide = DIFF_W'(target_ff) - DIFF_W'(meas_ff);
      if (err_wide[DIFF_W-1] != err_wide[DIFF_W-2]) begin
         err_sat = {err_wide[DIFF_W-1], {(SPEED_W-1){~err_wide[DIFF_W-1]}}};
      end else begin
         err_sat = SPEED_W'(err_wide);
      end

      integ_sum = trunc16(prod) + PROD_W'(integ_sum_ff[slot_ff]);
      if (integ_sum > int_lim_w) begin
         integ_new = INTEG_W'(int_lim_w);
      end else if (integ_sum < -int_lim_w) begin
         integ_new = INTEG_W'(-int_lim_w);
      end else begin
         integ_new = INTEG_W'(integ_sum);
      end

      if (prod > P_DERIV_MAX) begin
         deriv_sat = DERIV_W'(P_DERIV_MAX);
      end else if (prod < -P_DERIV_MAX) begin
         deriv_sat = DERIV_W'(-P_DERIV_MAX);
      end else begin
         deriv_sat = DERIV_W'(prod);
      end

      drive_trunc = trunc16(acc_ff);
      if (drive_trunc > drive_lim_w) begin
         drive_new = DRIVE_W'(drive_lim_w);
      end else if (drive_trunc < -drive_lim_w) begin
         drive_new = DRIVE_W'(-drive_lim_w);
      end else begin
         drive_new = DRIVE_W'(drive_trunc);
      end
      if ((target_ff > 0 && drive_new < 0) || (target_ff < 0 && drive_new > 0)) begin
         drive_new = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            last_count_ff[i] <= '0;
            integ_sum_ff[i]  <= '0;
            prev_err_ff[i]   <= '0;
         end
      end else begin
         case (state_ff)
            S_DELTA: begin
               last_count_ff[slot_ff] <= count_ff;
               if (cmd_ff == CMD_RESET) begin
                  integ_sum_ff[slot_ff] <= '0;
                  prev_err_ff[slot_ff]  <= '0;
               end
            end
            S_ERR: begin
               if (ctrl_off) begin
                  integ_sum_ff[slot_ff] <= '0;
                  prev_err_ff[slot_ff]  <= '0;
               end
            end
            S_DRV: begin
               integ_sum_ff[slot_ff] <= integ_ff;
               prev_err_ff[slot_ff]  <= err_ff;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         cmd_ff       <= req_if.command;
         chin_ff      <= req_if.channel;
         slot_ff      <= (CHANNELS > 1) ? CH_W'(req_if.channel) : '0;
         count_ff     <= req_if.encoder_count[COUNT_WIDTH-1:0];
         target_ff    <= req_if.target_speed;
         enable_ff    <= req_if.enable;
         brake_req_ff <= req_if.brake_on_reset;
      end
      case (state_ff)
         S_DELTA: begin
            delta_ff   <= count_ff - last_count_ff[slot_ff];
            meas_ff    <= '0;
            drive_ff   <= '0;
            stopped_ff <= 1'b1;
            brake_ff   <= (cmd_ff == CMD_RESET) ? brake_req_ff : 1'b1;
         end
         S_ERR:  meas_ff  <= meas_sat;
         S_ERRC: err_ff   <= err_sat;
         S_MPF:  diff_ff  <= DIFF_W'(err_ff) - DIFF_W'(prev_err_ff[slot_ff]);
         S_MPI:  integ_ff <= integ_new;
         S_MKP:  deriv_ff <= deriv_sat;
         S_MKI:  acc_ff   <= prod;
         S_MKD:  acc_ff   <= acc_ff + prod;
         S_SUM:  acc_ff   <= acc_ff + prod;
         S_DRV: begin
            drive_ff   <= drive_new;
            stopped_ff <= (drive_new == '0);
            brake_ff   <= (drive_new == '0);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == S_FINISH && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_FINISH && out_free) begin
         rsp_chan_ff    <= chin_ff;
         rsp_meas_ff    <= meas_ff;
         rsp_drive_ff   <= drive_ff;
         rsp_stopped_ff <= stopped_ff;
         rsp_brake_ff   <= brake_ff;
      end
   end

   `ESPC_ASSERT_NEXT(a_accept_starts, clock, reset, req_xfer, state_ff == S_DELTA,
      "transfer did not start sequencer")
   `ESPC_ASSERT(a_drive_flags, clock, reset,
      rsp_valid_ff && (rsp_drive_ff != '0) |-> !rsp_stopped_ff && !rsp_brake_ff,
      "driven result flagged as stopped")
   `ESPC_ASSERT(a_drive_bound, clock, reset,
      rsp_valid_ff |-> (rsp_drive_ff <= drive_lim_s) && (rsp_drive_ff >= -drive_lim_s),
      "drive beyond limit")
   `ESPC_ASSERT(a_integ_bound, clock, reset,
      state_ff == S_DRV |-> (integ_ff <= integ_lim_s) && (integ_ff >= -integ_lim_s),
      "integral beyond limit")
   `ESPC_ASSERT(a_reset_result, clock, reset,
      state_ff == S_FINISH && cmd_ff == CMD_RESET |-> meas_ff == '0 && drive_ff == '0 && stopped_ff,
      "reset command result not stopped")

endmodule

[verif/tb_encoder_speed_pid_controller_unit.sv]
module tb_encoder_speed_pid_controller_unit;
   import espc_pkg::*;

   localparam int     CYCLE_LIMIT = 250000;
   localparam int     HOLD_CYCLES = 300;
   localparam int     DRAIN_CYCLES = 20;
   localparam longint I32_HI = 64'sd2147483647;
   localparam longint I32_LO = -64'sd2147483648;
   localparam longint DERIV_LIMIT = 64'sd8796093022207;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED_FIRST = 4'd8;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED_LAST  = 4'd15;

   typedef struct {
      logic        channel;
      logic [31:0] speed;
      logic [16:0] drive;
      logic        stopped;
      logic        brake;
   } pid_result_type;

   logic clock;
   logic reset;

   espc_req_if req_if ();
   espc_rsp_if rsp_if ();
   espc_csr_if csr_if ();

   encoder_speed_pid_controller_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   espc_cfg_type   cfg_shadow;
   logic [31:0]    last_cnt [ESPC_CHANNELS];
   longint         integ_acc [ESPC_CHANNELS];
   longint         prev_err [ESPC_CHANNELS];
   logic [31:0]    encoder_pos [ESPC_CHANNELS];
   pid_result_type pending_drive_results [$];

   int  mismatch_count = 0;
   int  results_checked = 0;
   int  items_sent = 0;
   int  settings_used = 0;
   int  cycle_count = 0;
   bit  no_idle = 0;
   bit  hold_request = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic longint clamp_range(longint v, longint lo, longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic longint shift_toward_zero(longint v);
      if (v < 0) return -((-v) >>> 16);
      return v >>> 16;
   endfunction

   function automatic pid_result_type predict_pid_step(logic cmd, logic ch, logic [31:0] count,
         logic [23:0] target_raw, logic en, logic brk);
      pid_result_type r;
      logic [31:0] diff;
      longint target, delta, measured, err, integ, deriv, total, drv, lim, dl;
      target = longint'($signed(target_raw));
      measured = 0;
      drv = 0;
      r.stopped = 1'b1;
      r.brake = 1'b1;
      if (cmd == CMD_RESET) begin
         last_cnt[ch] = count;
         integ_acc[ch] = 0;
         prev_err[ch] = 0;
         r.brake = brk;
      end else begin
         diff = count - last_cnt[ch];
         delta = longint'($signed(diff));
         last_cnt[ch] = count;
         measured = clamp_range(delta * longint'(cfg_shadow.speed_per_pulse), I32_LO, I32_HI);
         if (!en || target == 0) begin
            integ_acc[ch] = 0;
            prev_err[ch] = 0;
         end else begin
            err = clamp_range(target - measured, I32_LO, I32_HI);
            lim = longint'(cfg_shadow.integral_limit);
            integ = clamp_range(integ_acc[ch]
                  + shift_toward_zero(err * longint'(cfg_shadow.period_fraction)), -lim, lim);
            deriv = clamp_range((err - prev_err[ch]) * longint'(cfg_shadow.period_inverse),
                  -DERIV_LIMIT, DERIV_LIMIT);
            total = longint'(cfg_shadow.gain_p) * err + longint'(cfg_shadow.gain_i) * integ
                  + longint'(cfg_shadow.gain_d) * deriv;
            dl = longint'(cfg_shadow.drive_limit);
            drv = clamp_range(shift_toward_zero(total), -dl, dl);
            if (target > 0 && drv < 0) drv = 0;
            if (target < 0 && drv > 0) drv = 0;
            integ_acc[ch] = integ;
            prev_err[ch] = err;
            if (drv != 0) begin
               r.stopped = 1'b0;
               r.brake = 1'b0;
            end
         end
      end
      r.channel = ch;
      r.speed = measured[31:0];
      r.drive = drv[16:0];
      return r;
   endfunction

   task automatic send_item(logic cmd, logic ch, logic [31:0] count, logic [23:0] target,
         logic en, logic brk);
      if (!no_idle && $urandom_range(0, 4) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_if.valid          <= 1'b1;
      req_if.command        <= cmd;
      req_if.channel        <= ch;
      req_if.encoder_count  <= count;
      req_if.target_speed   <= target;
      req_if.enable         <= en;
      req_if.brake_on_reset <= brk;
      do @(posedge clock); while (!req_if.ready);
      pending_drive_results.push_back(predict_pid_step(cmd, ch, count, target, en, brk));
      items_sent++;
   endtask

   task automatic send_tick(logic ch, logic [31:0] count, logic [23:0] target, logic en);
      encoder_pos[ch] = count;
      send_item(CMD_TICK, ch, count, target, en, 1'($urandom));
   endtask

   task automatic reset_channel(logic ch, logic [31:0] count, logic brk);
      encoder_pos[ch] = count;
      send_item(CMD_RESET, ch, count, 24'($urandom), 1'($urandom), brk);
   endtask

   task automatic wait_drained();
      req_if.valid <= 1'b0;
      while (pending_drive_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= data;
      do @(posedge clock); while (!csr_if.ready);
      case (idx)
         CSR_GAIN_P:      cfg_shadow.gain_p = data[REG_W-1:0];
         CSR_GAIN_I:      cfg_shadow.gain_i = data[REG_W-1:0];
         CSR_GAIN_D:      cfg_shadow.gain_d = data[REG_W-1:0];
         CSR_SPEED_PULSE: cfg_shadow.speed_per_pulse = data[REG_W-1:0];
         CSR_PERIOD_FRAC: cfg_shadow.period_fraction = data[REG_W-1:0];
         CSR_PERIOD_INV:  cfg_shadow.period_inverse = data[REG_W-1:0];
         CSR_INTEG_LIMIT: cfg_shadow.integral_limit = data[LIMIT_W-1:0];
         CSR_DRIVE_LIMIT: cfg_shadow.drive_limit = data[REG_W-1:0];
         default: ;
      endcase
   endtask

   task automatic program_settings(espc_cfg_type s);
      wait_drained();
      write_csr(CSR_GAIN_P,      CSR_DATA_W'(s.gain_p));
      write_csr(CSR_GAIN_I,      CSR_DATA_W'(s.gain_i));
      write_csr(CSR_GAIN_D,      CSR_DATA_W'(s.gain_d));
      write_csr(CSR_SPEED_PULSE, CSR_DATA_W'(s.speed_per_pulse));
      write_csr(CSR_PERIOD_FRAC, CSR_DATA_W'(s.period_fraction));
      write_csr(CSR_PERIOD_INV,  CSR_DATA_W'(s.period_inverse));
      write_csr(CSR_INTEG_LIMIT, s.integral_limit);
      write_csr(CSR_DRIVE_LIMIT, CSR_DATA_W'(s.drive_limit));
      if ($urandom_range(0, 1) == 0)
         write_csr(4'($urandom_range(CSR_UNUSED_FIRST, CSR_UNUSED_LAST)), CSR_DATA_W'($urandom));
      csr_if.valid <= 1'b0;
      settings_used++;
   endtask

   function automatic espc_cfg_type random_settings();
      espc_cfg_type s;
      s.gain_p = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1024));
      s.gain_i = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 512));
      s.gain_d = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 512));
      s.speed_per_pulse = ($urandom_range(0, 4) == 0) ? 16'($urandom)
            : 16'($urandom_range(64, 2048));
      s.period_fraction = 16'($urandom_range(1, 65535));
      s.period_inverse = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, 65535))
            : 16'($urandom_range(1, 1000));
      s.integral_limit = 24'($urandom);
      s.drive_limit = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4095));
      return s;
   endfunction

   task automatic random_item(int spread);
      logic ch;
      int   delta;
      int   tgt;
      int   pick;
      ch = 1'($urandom);
      delta = int'($urandom_range(0, 2 * spread)) - spread;
      tgt = int'($urandom_range(0, 400000));
      if ($urandom_range(0, 1) == 0) tgt = -tgt;
      pick = $urandom_range(0, 99);
      if (pick < 8)
         reset_channel(ch, 32'($urandom), 1'($urandom));
      else if (pick < 15)
         send_tick(ch, 32'($urandom), 24'($urandom), 1'($urandom));
      else if (pick < 20)
         send_tick(ch, encoder_pos[ch] + delta, 24'(tgt), 1'b0);
      else if (pick < 24)
         send_tick(ch, encoder_pos[ch] + delta, 24'd0, 1'b1);
      else
         send_tick(ch, encoder_pos[ch] + delta, 24'(tgt), 1'b1);
   endtask

   task automatic test_channel_reset();
      reset_channel(1'b0, 32'($urandom), 1'b1);
      reset_channel(1'b1, 32'hFFFF_FFFF, 1'b0);
      reset_channel(1'b0, 32'h0000_0000, 1'b0);
   endtask

   task automatic test_tick_cases();
      send_tick(1'b0, encoder_pos[0] + 10, 24'sd5000, 1'b0);
      send_tick(1'b1, encoder_pos[1] + 7, 24'sd0, 1'b1);
      send_tick(1'b0, encoder_pos[0] + 4, 24'sd20000, 1'b1);
      send_tick(1'b0, encoder_pos[0] + 5, 24'sd20000, 1'b1);
      send_tick(1'b1, encoder_pos[1] - 6, -24'sd15000, 1'b1);
      send_tick(1'b0, encoder_pos[0] + 3, 24'h7F_FFFF, 1'b1);
      send_tick(1'b1, encoder_pos[1] - 3, 24'h80_0000, 1'b1);
      send_tick(1'b0, encoder_pos[0] + 2000, 24'sd100, 1'b1);
      send_tick(1'b1, encoder_pos[1] - 2000, -24'sd100, 1'b1);
      reset_channel(1'b0, 32'h7FFF_FFF0, 1'b1);
      send_tick(1'b0, 32'h8000_0010, 24'sd8000, 1'b1);
      reset_channel(1'b1, 32'hFFFF_FFF0, 1'b0);
      send_tick(1'b1, 32'h0000_0010, 24'sd8000, 1'b1);
      reset_channel(1'b0, 32'h0000_0000, 1'b1);
      send_tick(1'b0, 32'h7FFF_FFFF, 24'sd1000, 1'b1);
      reset_channel(1'b1, 32'h0000_0000, 1'b1);
      send_tick(1'b1, 32'h8000_0000, 24'sd1000, 1'b1);
   endtask

   task automatic test_settings_extremes();
      espc_cfg_type s;
      s = '1;
      program_settings(s);
      reset_channel(1'b0, 32'($urandom), 1'b0);
      send_tick(1'b0, encoder_pos[0] + 1, 24'sd3000, 1'b1);
      send_tick(1'b0, encoder_pos[0] - 1, -24'sd3000, 1'b1);
      send_tick(1'b1, encoder_pos[1] + 40000, 24'h7F_FFFF, 1'b1);
      send_tick(1'b1, encoder_pos[1] - 90000, 24'h80_0000, 1'b1);
      s = '0;
      program_settings(s);
      send_tick(1'b0, encoder_pos[0] + 9, 24'sd3000, 1'b1);
      send_tick(1'b1, encoder_pos[1] - 9, -24'sd3000, 1'b1);
      s = CFG_RESET;
      s.period_fraction = '0;
      s.period_inverse = '0;
      program_settings(s);
      send_tick(1'b0, encoder_pos[0] + 3, 24'sd9000, 1'b1);
      send_tick(1'b0, encoder_pos[0] + 6, 24'sd9000, 1'b1);
      send_tick(1'b1, encoder_pos[1] - 2, -24'sd9000, 1'b1);
      wait_drained();
      write_csr(CSR_UNUSED_FIRST, '1);
      write_csr(CSR_UNUSED_LAST, CSR_DATA_W'($urandom));
      csr_if.valid <= 1'b0;
      program_settings(CFG_RESET);
   endtask

   task automatic test_backpressure();
      no_idle = 1;
      hold_request = 1;
      repeat (30) random_item(200);
      no_idle = 0;
   endtask

   task automatic test_random_ticks();
      repeat (5) begin
         program_settings(random_settings());
         repeat (104) random_item($urandom_range(0, 3) == 0 ? 5000 : 300);
      end
   endtask

   task automatic test_steady_stream();
      program_settings(CFG_RESET);
      no_idle = 1;
      repeat (50) random_item(300);
   endtask

   initial begin
      int stall_left;
      int hold_left;
      stall_left = 0;
      hold_left = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_left = HOLD_CYCLES;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
         end else if (!no_idle && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 12) - 1;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      pid_result_type e;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_drive_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result: ch=%0d speed=%0d drive=%0d stopped=%0b brake=%0b",
                     rsp_if.channel_out, rsp_if.measured_speed, rsp_if.drive,
                     rsp_if.stopped, rsp_if.brake);
         end else begin
            e = pending_drive_results.pop_front();
            results_checked++;
            if (rsp_if.channel_out !== e.channel || rsp_if.measured_speed !== e.speed
                  || rsp_if.drive !== e.drive || rsp_if.stopped !== e.stopped
                  || rsp_if.brake !== e.brake) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display({"mismatch on result %0d: expected ch=%0d speed=%0d drive=%0d ",
                        "stopped=%0b brake=%0b, got ch=%0d speed=%0d drive=%0d ",
                        "stopped=%0b brake=%0b"},
                        results_checked, e.channel, $signed(e.speed), $signed(e.drive),
                        e.stopped, e.brake, rsp_if.channel_out, rsp_if.measured_speed,
                        rsp_if.drive, rsp_if.stopped, rsp_if.brake);
            end
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles", cycle_count);
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      reset                 <= 1'b1;
      req_if.valid          <= 1'b0;
      req_if.command        <= CMD_TICK;
      req_if.channel        <= 1'b0;
      req_if.encoder_count  <= '0;
      req_if.target_speed   <= '0;
      req_if.enable         <= 1'b0;
      req_if.brake_on_reset <= 1'b0;
      csr_if.valid          <= 1'b0;
      csr_if.index          <= CSR_GAIN_P;
      csr_if.data           <= '0;
      cfg_shadow = CFG_RESET;
      foreach (last_cnt[i]) begin
         last_cnt[i] = '0;
         integ_acc[i] = 0;
         prev_err[i] = 0;
         encoder_pos[i] = '0;
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_channel_reset();
      test_tick_cases();
      test_settings_extremes();
      test_backpressure();
      test_random_ticks();
      test_steady_stream();
      req_if.valid <= 1'b0;
      while (pending_drive_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("run covered %0d items (ticks, channel resets, noise) under %0d settings",
            items_sent, settings_used);
      $display("%0d results checked, %0d mismatches", results_checked, mismatch_count);
      if (mismatch_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
